>>> rtl/mbsh_pkg.sv
// shared types, constants and mixing helpers for the byte stream hash
// no dependencies; imported by the front, queue, back and top modules
`default_nettype none

package mbsh_pkg;

   localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
   localparam logic [31:0] MIX_C2  = 32'h1b873593;
   localparam logic [31:0] MIX_ADD = 32'he6546b64;
   localparam logic [31:0] FIN_F1  = 32'h85ebca6b;
   localparam logic [31:0] FIN_F2  = 32'hc2b2ae35;

   localparam int MBSH_QUEUE_DEPTH = 4;

   // one unit of back-end work: an optional full block and an optional close
   typedef struct packed {
      logic        start;
      logic [31:0] seed;
      logic        do_block;
      logic [31:0] block_word;
      logic        do_final;
      logic        tail_valid;
      logic [23:0] tail_word;
      logic [31:0] byte_count;
   } op_type;

   function automatic logic [31:0] rotl15(input logic [31:0] v);
      return {v[16:0], v[31:17]};
   endfunction

   function automatic logic [31:0] rotl13(input logic [31:0] v);
      return {v[18:0], v[31:19]};
   endfunction

   // h = rotl13(h) * 5 + add, the multiply by five is a shift and add
   function automatic logic [31:0] mix_hash(input logic [31:0] v);
      logic [31:0] r;
      r = rotl13(v);
      return r + {r[29:0], 2'b00} + MIX_ADD;
   endfunction

endpackage

`default_nettype wire

>>> rtl/mbsh_front.sv
// front end: accepts bytes, assembles little-endian blocks, tracks the count
// and emits one op per finished block or closing word; uses mbsh_pkg
`default_nettype none

module mbsh_front import mbsh_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [31:0] seed,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic        req_has_byte,
   input  wire logic        req_is_last,
   input  wire logic        queue_full,
   output logic             push,
   output op_type           push_op
);

   logic        active_ff, active_in;
   logic        first_ff, first_in;
   logic [31:0] count_ff, count_in;
   logic [23:0] pend_ff, pend_in;
   logic [31:0] seed_ff, seed_in;

   logic        accept;
   logic [31:0] cnt;
   logic [23:0] pend;
   logic [1:0]  pos;
   logic        do_block;

   assign req_stall = queue_full;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      active_in = active_ff;
      first_in  = first_ff;
      count_in  = count_ff;
      pend_in   = pend_ff;
      seed_in   = seed_ff;
      push      = 1'b0;
      do_block  = 1'b0;

      // a closed message restarts from the seed register
      cnt  = active_ff ? count_ff : '0;
      pend = active_ff ? pend_ff : '0;
      pos  = cnt[1:0];

      push_op            = '0;
      push_op.seed       = active_ff ? seed_ff : seed;
      push_op.start      = active_ff ? first_ff : 1'b1;

      if (accept) begin
         seed_in  = push_op.seed;
         pend_in  = pend;
         count_in = cnt;
         if (req_has_byte) begin
            count_in = cnt + 32'd1;
            case (pos)
               2'd0: pend_in = {pend[23:8], req_byte_value};
               2'd1: pend_in = {pend[23:16], req_byte_value, pend[7:0]};
               2'd2: pend_in = {req_byte_value, pend[15:0]};
               default: begin
                  do_block = 1'b1;
                  pend_in  = '0;
               end
            endcase
         end
         push_op.do_block   = do_block;
         push_op.block_word = {req_byte_value, pend};
         push_op.do_final   = req_is_last;
         push_op.tail_valid = count_in[1:0] != 2'd0;
         push_op.tail_word  = pend_in;
         push_op.byte_count = count_in;
         push      = do_block | req_is_last;
         first_in  = push ? 1'b0 : push_op.start;
         active_in = ~req_is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         first_ff  <= 1'b1;
         count_ff  <= '0;
         pend_ff   <= '0;
      end else begin
         active_ff <= active_in;
         first_ff  <= first_in;
         count_ff  <= count_in;
         pend_ff   <= pend_in;
      end
      seed_ff <= seed_in;
   end

endmodule

`default_nettype wire

>>> rtl/mbsh_queue.sv
// short fifo of ops between the front and back ends
// depends on mbsh_pkg for the op type
`default_nettype none

module mbsh_queue import mbsh_pkg::*; #(
   parameter int DEPTH = MBSH_QUEUE_DEPTH
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire op_type push_op,
   output logic        full,
   input  wire logic   pop,
   output op_type      pop_op,
   output logic        empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   op_type          entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full   = count_ff == CW'(DEPTH);
   assign empty  = count_ff == '0;
   assign pop_op = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

>>> rtl/mbsh_back.sv
// back end: block mixing, tail mixing and finalizer on one shared multiplier,
// plus the result register; uses mbsh_pkg
`default_nettype none

module mbsh_back import mbsh_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   queue_empty,
   input  wire op_type pop_op,
   output logic        pop,
   output logic        rsp_valid,
   input  wire logic   rsp_stall,
   output logic [31:0] rsp_hash_value
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_B1   = 4'd1;
   localparam logic [3:0] S_B2   = 4'd2;
   localparam logic [3:0] S_B3   = 4'd3;
   localparam logic [3:0] S_T1   = 4'd4;
   localparam logic [3:0] S_T2   = 4'd5;
   localparam logic [3:0] S_T3   = 4'd6;
   localparam logic [3:0] S_F1   = 4'd7;
   localparam logic [3:0] S_F2   = 4'd8;
   localparam logic [3:0] S_F3   = 4'd9;

   logic [3:0]  state_ff, state_in;
   op_type      op_ff, op_in;
   logic [31:0] h_ff, h_in;
   logic [31:0] acc_ff, acc_in;
   logic        valid_ff, valid_in;
   logic [31:0] hash_ff, hash_in;

   logic [31:0] mul_a, mul_b, prod;

   assign prod           = 32'(mul_a * mul_b);
   assign rsp_valid      = valid_ff;
   assign rsp_hash_value = hash_ff;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      h_in     = h_ff;
      acc_in   = acc_ff;
      valid_in = valid_ff & rsp_stall;
      hash_in  = hash_ff;
      pop      = 1'b0;
      mul_a    = acc_ff;
      mul_b    = MIX_C1;

      case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               pop   = 1'b1;
               op_in = pop_op;
               if (pop_op.start) begin
                  h_in = pop_op.seed;
               end
               if (pop_op.do_block) begin
                  state_in = S_B1;
               end else begin
                  state_in = pop_op.tail_valid ? S_T1 : S_T3;
               end
            end
         end
         S_B1: begin
            mul_a    = op_ff.block_word;
            mul_b    = MIX_C1;
            acc_in   = prod;
            state_in = S_B2;
         end
         S_B2: begin
            mul_a    = rotl15(acc_ff);
            mul_b    = MIX_C2;
            acc_in   = prod;
            state_in = S_B3;
         end
         S_B3: begin
            h_in = mix_hash(h_ff ^ acc_ff);
            if (op_ff.do_final) begin
               state_in = op_ff.tail_valid ? S_T1 : S_T3;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_T1: begin
            mul_a    = {8'd0, op_ff.tail_word};
            mul_b    = MIX_C1;
            acc_in   = prod;
            state_in = S_T2;
         end
         S_T2: begin
            mul_a    = rotl15(acc_ff);
            mul_b    = MIX_C2;
            acc_in   = prod;
            state_in = S_T3;
         end
         S_T3: begin
            // tail word only counts when 1 to 3 bytes are left over
            acc_in   = h_ff ^ (op_ff.tail_valid ? acc_ff : 32'd0) ^ op_ff.byte_count;
            state_in = S_F1;
         end
         S_F1: begin
            mul_a    = acc_ff ^ {16'd0, acc_ff[31:16]};
            mul_b    = FIN_F1;
            acc_in   = prod;
            state_in = S_F2;
         end
         S_F2: begin
            mul_a    = acc_ff ^ {13'd0, acc_ff[31:13]};
            mul_b    = FIN_F2;
            acc_in   = prod;
            state_in = S_F3;
         end
         S_F3: begin
            // wait here while the previous hash still sits unclaimed
            if (!valid_ff || !rsp_stall) begin
               valid_in = 1'b1;
               hash_in  = acc_ff ^ {16'd0, acc_ff[31:16]};
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      op_ff   <= op_in;
      h_ff    <= h_in;
      acc_ff  <= acc_in;
      hash_ff <= hash_in;
   end

endmodule

`default_nettype wire

>>> rtl/murmur3_byte_stream_hash.sv
// top level of the 32-bit murmur3 byte stream hash: seed register and the
// front end, op queue and back end; depends on mbsh_pkg and the mbsh_* modules
`default_nettype none

// Hashes a message fed one byte per word (req_has_byte marks a real byte,
// req_is_last closes the message and yields one rsp word with the finalized
// hash). The seed in the csr register is sampled when a message opens. The
// front end takes one word per cycle while its op queue (QUEUE_DEPTH ops) has
// room; the back end works through each 4-byte block (two multiplies and the
// hash mix) and each closing word (tail scramble, count fold and finalizer)
// one op at a time, all on one shared 32x32 multiplier, so long messages
// stream at about one byte per cycle unless rsp_stall holds the back end.
module murmur3_byte_stream_hash import mbsh_pkg::*; #(
   parameter int QUEUE_DEPTH = MBSH_QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic        req_has_byte,
   input  wire logic        req_is_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_hash_value
);

   logic [31:0] seed_ff, seed_in;
   logic        push, pop, queue_full, queue_empty;
   op_type      push_op, pop_op;

   assign seed_in = csr_wr_en ? csr_wr_data : seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   mbsh_front u_front (
      .clock          (clock),
      .reset          (reset),
      .seed           (seed_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_byte_value (req_byte_value),
      .req_has_byte   (req_has_byte),
      .req_is_last    (req_is_last),
      .queue_full     (queue_full),
      .push           (push),
      .push_op        (push_op)
   );

   mbsh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (queue_full),
      .pop     (pop),
      .pop_op  (pop_op),
      .empty   (queue_empty)
   );

   mbsh_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .pop_op         (pop_op),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

`default_nettype wire
